>>> sv/skat_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the sorted key accumulate table.
// No dependencies; imported by skat_scale, skat_cell and the top level.
package skat_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam logic [31:0] SCALE_RESET = 32'd16777216;  // 1.0 in Q7.24

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_RANGE    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;   // compare broadcast key / index, load collect chain
    logic rd;    // compare phase selects by position, not by key
    logic walk;  // collect chain moves one cell toward cell 0
    logic ins;   // open a slot at the sorted position
    logic wr;    // selected cell takes the merged sum
  } cell_ctl_t;

  // Round to nearest (ties up) after the Q7.24 product, then saturate to 32 bits
  function automatic logic [31:0] rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [39:0] q;
    t = p + 64'sd8388608;
    q = t[63:24];
    if (q > 40'sh007FFFFFFF) begin
      rnd_sat = 32'h7FFF_FFFF;
    end else if (q < -40'sh0080000000) begin
      rnd_sat = 32'h8000_0000;
    end else begin
      rnd_sat = q[31:0];
    end
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

>>> sv/skat_scale.sv
`timescale 1ns / 1ps
// Shared 32x32 signed multiplier with registered product and Q7.24 rounding.
// Depends on skat_pkg (rnd_sat).
module skat_scale import skat_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] part,
  input  logic [31:0] scale,
  output logic [31:0] scaled
);

  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed(part) * $signed(scale);
    end
  end

  assign scaled = rnd_sat(prod);

endmodule

>>> sv/skat_cell.sv
`timescale 1ns / 1ps
// One table slot: holds a key and coefficient, compares against the broadcast key,
// shifts up on insert and forwards a collect register toward cell 0. Uses skat_pkg.
module skat_cell import skat_pkg::*; #(
  parameter int POS = 0,
  parameter int KW  = KEY_BITS_DEF,
  parameter int CW  = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] count,
  input  logic [7:0]    rd_index,
  input  logic [KW-1:0] new_key,
  input  logic [31:0]   new_re,
  input  logic [31:0]   new_im,
  input  logic [31:0]   sum_re,
  input  logic [31:0]   sum_im,
  input  logic [KW-1:0] prev_key,
  input  logic [31:0]   prev_re,
  input  logic [31:0]   prev_im,
  input  logic          prev_lt,
  input  logic [KW-1:0] nxt_col_key,
  input  logic [31:0]   nxt_col_re,
  input  logic [31:0]   nxt_col_im,
  input  logic          nxt_col_hit,
  output logic [KW-1:0] ent_key,
  output logic [31:0]   ent_re,
  output logic [31:0]   ent_im,
  output logic          lt,
  output logic [KW-1:0] col_key,
  output logic [31:0]   col_re,
  output logic [31:0]   col_im,
  output logic          col_hit
);

  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic [IW-1:0] POS_V = IW'(POS);

  logic occ;
  logic hit;
  logic sel;

  assign occ = POS_V < IW'(count);
  assign hit = ctl.rd ? (occ && (POS_V == IW'(rd_index))) : (occ && (ent_key == new_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= 1'b0;
      lt      <= 1'b0;
      col_hit <= 1'b0;
    end else if (ctl.cmp) begin
      sel     <= hit;
      lt      <= occ && (ent_key < new_key);
      col_hit <= hit;
    end else if (ctl.walk) begin
      col_hit <= nxt_col_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      col_key <= ent_key;
      col_re  <= ent_re;
      col_im  <= ent_im;
    end else if (ctl.walk) begin
      col_key <= nxt_col_key;
      col_re  <= nxt_col_re;
      col_im  <= nxt_col_im;
    end
  end

  // lower neighbor below the key: this is the sorted slot; otherwise take its entry
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      if (prev_lt) begin
        ent_key <= new_key;
        ent_re  <= new_re;
        ent_im  <= new_im;
      end else begin
        ent_key <= prev_key;
        ent_re  <= prev_re;
        ent_im  <= prev_im;
      end
    end else if (ctl.wr && sel) begin
      ent_re <= sum_re;
      ent_im <= sum_im;
    end
  end

endmodule

>>> sv/sorted_key_accumulate_table_top.sv
`timescale 1ns / 1ps
// Sorted key accumulate table: row of TABLE_DEPTH cells kept in ascending key order.
// Steps: an insert scales (S_MUL_RE, S_MUL_IM), then S_CMP, S_WALK and, on a merge, S_WRITE; a read
// runs S_CMP, S_WALK; range miss and clear go to S_DONE. New items are taken only in S_IDLE.
// The collect chain walks one cell per cycle toward cell 0 and sets the insert/read time.
// Reset (rst, synchronous): entry count 0, scale 1.0; no clearing pass, table slots stay as they are.
// Uses skat_pkg, skat_scale, skat_cell.
module sorted_key_accumulate_table_top import skat_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] coeff_re,
  input  logic [31:0] coeff_im,
  input  logic [7:0]  index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [31:0] out_re,
  output logic [31:0] out_im,
  output logic [8:0]  entry_total
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_RE,
    S_MUL_IM,
    S_CMP,
    S_WALK,
    S_WRITE,
    S_DONE
  } state_t;

  state_t        state;
  opcode_t       op_r;
  logic [KW-1:0] key_r;
  logic [31:0]   re_r;
  logic [31:0]   im_r;
  logic [7:0]    idx_r;
  logic [31:0]   scale;
  logic [CW-1:0] count;
  logic [CW-1:0] w;
  logic [31:0]   sre;
  logic [31:0]   sim;

  status_t       res_status;
  logic [KW-1:0] res_key;
  logic [31:0]   res_re;
  logic [31:0]   res_im;

  logic          mul_en;
  logic [31:0]   mul_part;
  logic [31:0]   scaled;
  logic          full;
  logic          ins_pulse;
  cell_ctl_t     ctl;

  logic [KW-1:0] ent_key [TABLE_DEPTH];
  logic [31:0]   ent_re  [TABLE_DEPTH];
  logic [31:0]   ent_im  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt;
  logic [KW-1:0] col_key [TABLE_DEPTH];
  logic [31:0]   col_re  [TABLE_DEPTH];
  logic [31:0]   col_im  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] col_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign full      = (count == CW'(TABLE_DEPTH));
  assign ins_pulse = (state == S_WALK) && !col_hit[0] && (w == count) && !full
                     && (op_r == OP_INSERT);

  assign mul_en   = (state == S_MUL_RE) || (state == S_MUL_IM);
  assign mul_part = (state == S_MUL_RE) ? re_r : im_r;

  always_comb begin
    ctl.cmp  = (state == S_CMP);
    ctl.rd   = (op_r == OP_READ);
    ctl.walk = (state == S_WALK);
    ctl.ins  = ins_pulse;
    ctl.wr   = (state == S_WRITE);
  end

  skat_scale u_scale (
    .clk    (clk),
    .en     (mul_en),
    .part   (mul_part),
    .scale  (scale),
    .scaled (scaled)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KW-1:0] p_key;
    logic [31:0]   p_re;
    logic [31:0]   p_im;
    logic          p_lt;
    logic [KW-1:0] n_key;
    logic [31:0]   n_re;
    logic [31:0]   n_im;
    logic          n_hit;

    if (i == 0) begin : g_first
      assign p_key = '0;
      assign p_re  = '0;
      assign p_im  = '0;
      assign p_lt  = 1'b1;
    end else begin : g_mid
      assign p_key = ent_key[i-1];
      assign p_re  = ent_re[i-1];
      assign p_im  = ent_im[i-1];
      assign p_lt  = lt[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign n_key = '0;
      assign n_re  = '0;
      assign n_im  = '0;
      assign n_hit = 1'b0;
    end else begin : g_inner
      assign n_key = col_key[i+1];
      assign n_re  = col_re[i+1];
      assign n_im  = col_im[i+1];
      assign n_hit = col_hit[i+1];
    end

    skat_cell #(
      .POS (i),
      .KW  (KW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .count       (count),
      .rd_index    (idx_r),
      .new_key     (key_r),
      .new_re      (sre),
      .new_im      (sim),
      .sum_re      (res_re),
      .sum_im      (res_im),
      .prev_key    (p_key),
      .prev_re     (p_re),
      .prev_im     (p_im),
      .prev_lt     (p_lt),
      .nxt_col_key (n_key),
      .nxt_col_re  (n_re),
      .nxt_col_im  (n_im),
      .nxt_col_hit (n_hit),
      .ent_key     (ent_key[i]),
      .ent_re      (ent_re[i]),
      .ent_im      (ent_im[i]),
      .lt          (lt[i]),
      .col_key     (col_key[i]),
      .col_re      (col_re[i]),
      .col_im      (col_im[i]),
      .col_hit     (col_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op_r       <= OP_INSERT;
      count      <= '0;
      w          <= '0;
      scale      <= SCALE_RESET;
      out_valid  <= 1'b0;
      res_status <= ST_MERGED;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale <= cfg_data;
      end
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= opcode_t'(opcode);
            key_r <= key[KW-1:0];
            re_r  <= coeff_re;
            im_r  <= coeff_im;
            idx_r <= index;
            case (opcode_t'(opcode))
              OP_INSERT: begin
                state <= S_MUL_RE;
              end
              OP_READ: begin
                if (IW'(index) < IW'(count)) begin
                  state <= S_CMP;
                end else begin
                  res_status <= ST_RANGE;
                  res_key    <= '0;
                  res_re     <= '0;
                  res_im     <= '0;
                  state      <= S_DONE;
                end
              end
              OP_CLEAR: begin
                count      <= '0;
                res_status <= ST_CLEARED;
                res_key    <= '0;
                res_re     <= '0;
                res_im     <= '0;
                state      <= S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_MUL_RE: begin
          state <= S_MUL_IM;
        end

        S_MUL_IM: begin
          sre   <= scaled;
          state <= S_CMP;
        end

        S_CMP: begin
          sim   <= scaled;
          w     <= '0;
          state <= S_WALK;
        end

        // head of the collect chain is cell w
        S_WALK: begin
          if (col_hit[0]) begin
            res_key <= col_key[0];
            if (op_r == OP_READ) begin
              res_status <= ST_READ_OK;
              res_re     <= col_re[0];
              res_im     <= col_im[0];
              state      <= S_DONE;
            end else begin
              res_status <= ST_MERGED;
              res_re     <= sat_add(col_re[0], sre);
              res_im     <= sat_add(col_im[0], sim);
              state      <= S_WRITE;
            end
          end else if (w == count) begin
            res_key <= key_r;
            res_re  <= sre;
            res_im  <= sim;
            if (full) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_INSERTED;
              count      <= count + CW'(1);
            end
            state <= S_DONE;
          end else begin
            w <= w + CW'(1);
          end
        end

        S_WRITE: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            out_key     <= 32'(res_key);
            out_re      <= res_re;
            out_im      <= res_im;
            entry_total <= 9'(count);
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ins_pulse |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the table by one");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> $onehot0(col_hit))
    else $error("more than one cell selected on the collect chain");

  a_read_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && col_hit[0] && op_r == OP_READ) |-> (IW'(w) == IW'(idx_r)))
    else $error("read beat arrived from the wrong position");

  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not moved to the output register");

endmodule
